[rtl/rac_pkg.sv]
// rac_pkg: shared types and codes for the region access checker
// used by rac_ctrl, rac_dpath and region_access_checker; no dependencies

package rac_pkg;

    // item kinds
    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_ADD   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_BADPARAM = 3'd2;
    localparam logic [2:0] ST_OVERLAP  = 3'd3;
    localparam logic [2:0] ST_BADADDR  = 3'd4;

    // access mode encoding: bit 0 grants read, bit 1 grants write
    localparam int MODE_RD_BIT = 0;
    localparam int MODE_WR_BIT = 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted input word, rewind scan index
        logic scan;     // examine one table entry or settle a trivial item
        logic commit;   // apply table update and load output register
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic done;     // result settles on this scan step
        logic out_free; // output register can take a word this cycle
    } dp_stat_t;

endpackage

[rtl/region_access_checker.sv]
// region_access_checker: after an input word is accepted, the scan visits the
// stored regions one at a time on the single compare unit in rac_dpath, and
// the settled result waits while the output register holds a word that the
// result side stalls; a new word is taken only after the previous result has
// been loaded into the output register.
// reset (rst_n, async, active low) empties the table and the output register;
// region contents are undefined until written and are never read before that
// depends on rac_pkg, rac_ctrl and rac_dpath

module region_access_checker #(
    parameter int REGION_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [7:0]  length,
    input  logic [15:0] region_base,
    input  logic [16:0] region_size,
    input  logic [1:0]  region_mode,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        read_allowed,
    output logic        write_allowed,
    output logic [1:0]  access_mode,
    output logic [3:0]  regions_used
);
    import rac_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: idle -> scan (one entry per cycle; items that settle without a
    // walk leave on their first scan step) -> finish (waits for the output register)
    rac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // region table, scan compare unit and output register
    rac_dpath #(
        .REGION_SLOTS (REGION_SLOTS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .address       (address),
        .length        (length),
        .region_base   (region_base),
        .region_size   (region_size),
        .region_mode   (region_mode),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .read_allowed  (read_allowed),
        .write_allowed (write_allowed),
        .access_mode   (access_mode),
        .regions_used  (regions_used)
    );

endmodule

[rtl/rac_ctrl.sv]
// rac_ctrl: sequencer for the region access checker
// depends on rac_pkg for state and command/status types

module rac_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rac_pkg::dp_stat_t  stat,
    output rac_pkg::ctrl_cmd_t cmd
);
    import rac_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/rac_dpath.sv]
// rac_dpath: region table, one-entry-per-cycle scan unit and output register
// depends on rac_pkg for codes and command/status types

module rac_dpath #(
    parameter int REGION_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rac_pkg::ctrl_cmd_t cmd,
    output rac_pkg::dp_stat_t  stat,
    input  logic [1:0]         kind,
    input  logic [15:0]        address,
    input  logic [7:0]         length,
    input  logic [15:0]        region_base,
    input  logic [16:0]        region_size,
    input  logic [1:0]         region_mode,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic               read_allowed,
    output logic               write_allowed,
    output logic [1:0]         access_mode,
    output logic [3:0]         regions_used
);
    import rac_pkg::*;

    localparam int IDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int CNT_W = $clog2(REGION_SLOTS + 1);

    // region table, contents undefined until written
    logic [15:0] base_mem [REGION_SLOTS];
    logic [16:0] size_mem [REGION_SLOTS];
    logic [1:0]  mode_mem [REGION_SLOTS];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // table entry at idx_reg, registered from the entry addressed by idx_next
    logic [15:0] rd_base_reg;
    logic [16:0] rd_size_reg;
    logic [1:0]  rd_mode_reg;

    // latched item
    logic [1:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  len_reg;
    logic [15:0] rbase_reg;
    logic [16:0] rsize_reg;
    logic [1:0]  rmode_reg;

    // settled result
    logic [2:0] res_status_reg;
    logic [1:0] res_mode_reg;

    logic       out_valid_reg;
    logic [2:0] out_status_reg;
    logic [1:0] out_mode_reg;
    logic [3:0] out_used_reg;

    logic [15:0] cur_base;
    logic [16:0] cur_size;
    logic [17:0] cur_end;
    logic [17:0] q_end;
    logic [17:0] new_end;
    logic        holds;
    logic        fits;
    logic        ovl;
    logic        early;
    logic [2:0]  early_status;
    logic        hit;
    logic        last;
    logic [2:0]  scan_status;
    logic [1:0]  scan_mode;
    logic        do_write;
    logic [31:0] used_ext;

    assign cur_base = rd_base_reg;
    assign cur_size = rd_size_reg;
    assign cur_end  = {2'b00, cur_base} + {1'b0, cur_size};
    assign q_end    = {2'b00, addr_reg} + {10'd0, len_reg};
    assign new_end  = {2'b00, rbase_reg} + {1'b0, rsize_reg};

    assign holds = (addr_reg >= cur_base) && ({2'b00, addr_reg} < cur_end);
    assign fits  = (q_end <= cur_end);
    assign ovl   = ({2'b00, cur_base} < new_end) && ({2'b00, rbase_reg} < cur_end);

    // items that need no table walk
    always_comb
    begin
        early        = 1'b1;
        early_status = ST_BADPARAM;
        case (kind_reg)
            KIND_CHECK:
            begin
                if (len_reg == 8'd0)
                begin
                    early_status = ST_BADPARAM;
                end
                else if (count_reg == '0)
                begin
                    early_status = ST_BADADDR;
                end
                else
                begin
                    early = 1'b0;
                end
            end
            KIND_ADD:
            begin
                if (count_reg >= CNT_W'(REGION_SLOTS))
                begin
                    early_status = ST_FULL;
                end
                else if (rsize_reg == 17'd0)
                begin
                    early_status = ST_BADPARAM;
                end
                else if (count_reg == '0)
                begin
                    early_status = ST_OK;
                end
                else
                begin
                    early = 1'b0;
                end
            end
            KIND_CLEAR:
            begin
                early_status = ST_OK;
            end
            default:
            begin
                early_status = ST_BADPARAM;
            end
        endcase
    end

    assign hit  = (kind_reg == KIND_CHECK) ? holds : ovl;
    assign last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        scan_mode = 2'd0;
        if (kind_reg == KIND_CHECK)
        begin
            if (hit && fits)
            begin
                scan_status = ST_OK;
                scan_mode   = rd_mode_reg;
            end
            else
            begin
                // first holding region is final even when the range overruns it
                scan_status = ST_BADADDR;
            end
        end
        else
        begin
            scan_status = hit ? ST_OVERLAP : ST_OK;
        end
    end

    // scan index, also the read address for the next entry
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.scan && !early && !hit && !last)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign stat.done     = early || hit || last;
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign do_write = cmd.commit && (kind_reg == KIND_ADD) && (res_status_reg == ST_OK);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            if (kind_reg == KIND_CLEAR)
            begin
                count_next = '0;
            end
            else if (do_write)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    assign used_ext = 32'(count_next);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and table
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        rd_base_reg <= base_mem[idx_next];
        rd_size_reg <= size_mem[idx_next];
        rd_mode_reg <= mode_mem[idx_next];
        if (cmd.load)
        begin
            kind_reg  <= kind;
            addr_reg  <= address;
            len_reg   <= length;
            rbase_reg <= region_base;
            rsize_reg <= region_size;
            rmode_reg <= region_mode;
        end
        if (cmd.scan)
        begin
            if (early)
            begin
                res_status_reg <= early_status;
                res_mode_reg   <= 2'd0;
            end
            else if (hit || last)
            begin
                res_status_reg <= scan_status;
                res_mode_reg   <= scan_mode;
            end
        end
        if (do_write)
        begin
            base_mem[count_reg[IDX_W-1:0]] <= rbase_reg;
            size_mem[count_reg[IDX_W-1:0]] <= rsize_reg;
            mode_mem[count_reg[IDX_W-1:0]] <= rmode_reg;
        end
        if (cmd.commit)
        begin
            out_status_reg <= res_status_reg;
            out_mode_reg   <= res_mode_reg;
            out_used_reg   <= used_ext[3:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign access_mode   = out_mode_reg;
    assign read_allowed  = out_mode_reg[MODE_RD_BIT];
    assign write_allowed = out_mode_reg[MODE_WR_BIT];
    assign regions_used  = out_used_reg;

endmodule
